@@ src/assert_macros.svh @@
// assertion macros shared by the wrapped angle command rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define WAPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define WAPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wapc_pkg.sv @@
// constants, types and helpers for the wrapped angle position command block
package wapc_pkg;

  localparam int TURN_UNITS  = 36000;
  localparam int FULL_ERROR  = 6000;
  localparam int MOTOR_COUNT = 2;

  localparam int SEL_W      = 1;
  localparam int ANGLE_W    = 16;
  localparam int ENC_W      = 16;
  localparam int SPEED_W    = 10;
  localparam int WIN_N      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // |delta| never exceeds half a turn
  localparam int ERR_W     = $clog2(TURN_UNITS / 2 + 1);
  // err * span stays below FULL_ERROR * max speed
  localparam int PROD_W    = $clog2(FULL_ERROR * ((1 << SPEED_W) - 1));
  // exact reciprocal for floor(p / FULL_ERROR) over PROD_W-bit p
  localparam int DIV_SHIFT = PROD_W + $clog2(FULL_ERROR);
  localparam int RECIP_W   = PROD_W + 2;
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_SHIFT) + 64'(FULL_ERROR) - 64'd1) / 64'(FULL_ERROR);

  localparam logic [ANGLE_W-1:0] TURN_A = ANGLE_W'(TURN_UNITS);
  localparam logic [ANGLE_W-1:0] HALF_A = ANGLE_W'(TURN_UNITS / 2);

  localparam logic [ANGLE_W-1:0] RST_LIM_LO_0    = ANGLE_W'(34300);
  localparam logic [ANGLE_W-1:0] RST_LIM_HI_0    = ANGLE_W'(2000);
  localparam logic [ANGLE_W-1:0] RST_LIM_LO_1    = ANGLE_W'(27000);
  localparam logic [ANGLE_W-1:0] RST_LIM_HI_1    = ANGLE_W'(9000);
  localparam logic [SPEED_W-1:0] RST_SPEED_FLOOR = SPEED_W'(1);
  localparam logic [SPEED_W-1:0] RST_SPEED_CEIL  = SPEED_W'(150);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIM_LO_0,
    CFG_LIM_HI_0,
    CFG_LIM_LO_1,
    CFG_LIM_HI_1,
    CFG_SPEED_FLOOR,
    CFG_SPEED_CEIL
  } wapc_cfg_idx_t;

  typedef struct packed {
    logic [WIN_N-1:0][ANGLE_W-1:0] lim_lo;
    logic [WIN_N-1:0][ANGLE_W-1:0] lim_hi;
    logic [SPEED_W-1:0]            spd_floor;
    logic [SPEED_W-1:0]            spd_ceil;
  } wapc_cfg_t;

  // one conditional subtract covers any 16-bit value for a full turn of 36000
  function automatic logic [ANGLE_W-1:0] wrap_turn(input logic [ANGLE_W-1:0] a);
    return (a >= TURN_A) ? (a - TURN_A) : a;
  endfunction

endpackage

@@ src/wapc_cmd_if.sv @@
// command channel: motor select, target angle and encoder position
interface wapc_cmd_if import wapc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SEL_W-1:0]   motor_select;
  logic [ANGLE_W-1:0] req_angle;
  logic [ENC_W-1:0]   encoder_position;

  modport source (output valid, motor_select, req_angle, encoder_position,
                  input ready);
  modport sink (input valid, motor_select, req_angle, encoder_position,
                output ready);
endinterface

@@ src/wapc_res_if.sv @@
// result channel: safe target, signed target, delta, speed and direction
interface wapc_res_if import wapc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ANGLE_W-1:0]        safe_target;
  logic signed [ANGLE_W-1:0] centred_target;
  logic signed [ANGLE_W-1:0] shortest_delta;
  logic [SPEED_W-1:0]        speed_cap;
  logic                      turn_direction;

  modport source (output valid, safe_target, centred_target, shortest_delta, speed_cap,
                  turn_direction, input ready);
  modport sink (input valid, safe_target, centred_target, shortest_delta, speed_cap,
                turn_direction, output ready);
endinterface

@@ src/wapc_cfg_if.sv @@
// configuration write channel: register index and data
interface wapc_cfg_if import wapc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/wapc_cfg_regs.sv @@
// configuration register file, window edges stored already reduced to one turn
module wapc_cfg_regs import wapc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  wapc_cfg_if.sink  cfg_wr,
  output wapc_cfg_t cfg
);

  wapc_cfg_t          cfg_r;
  wapc_cfg_t          cfg_nxt;
  logic [ANGLE_W-1:0] wr_angle;

  assign cfg_wr.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt  = cfg_r;
    wr_angle = wrap_turn(cfg_wr.data[ANGLE_W-1:0]);
    if (cfg_wr.valid) begin
      case (wapc_cfg_idx_t'(cfg_wr.index))
        CFG_LIM_LO_0:    cfg_nxt.lim_lo[0]  = wr_angle;
        CFG_LIM_HI_0:    cfg_nxt.lim_hi[0]  = wr_angle;
        CFG_LIM_LO_1:    cfg_nxt.lim_lo[1]  = wr_angle;
        CFG_LIM_HI_1:    cfg_nxt.lim_hi[1]  = wr_angle;
        CFG_SPEED_FLOOR: cfg_nxt.spd_floor  = cfg_wr.data[SPEED_W-1:0];
        CFG_SPEED_CEIL:  cfg_nxt.spd_ceil   = cfg_wr.data[SPEED_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lim_lo[0] <= RST_LIM_LO_0;
      cfg_r.lim_hi[0] <= RST_LIM_HI_0;
      cfg_r.lim_lo[1] <= RST_LIM_LO_1;
      cfg_r.lim_hi[1] <= RST_LIM_HI_1;
      cfg_r.spd_floor <= RST_SPEED_FLOOR;
      cfg_r.spd_ceil  <= RST_SPEED_CEIL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ src/wrapped_angle_position_command_top.sv @@
// top level of the wrapped angle position command pipeline
//
// channel   dir  payload                                                   transaction
// in_cmd    in   motor_select, req_angle, encoder_position                 valid & ready
// out_res   out  safe_target, centred_target, shortest_delta, speed_cap,   valid & ready
//                turn_direction
// cfg_wr    in   index, data (always ready)                                valid & ready
//
// one command per cycle sustained while out_res is ready
// stages: encoder scale multiply, window clamp, wrapped delta, ramp multiply,
// reciprocal divide, output register; the direction hold is read and written in stage 3
// a stall on out_res holds only occupied stages, empty stages keep taking commands
// rst_n (synchronous) clears stage valids and held directions and loads default limits
`include "assert_macros.svh"

module wrapped_angle_position_command_top import wapc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wapc_cfg_if.sink    cfg_wr,
  wapc_cmd_if.sink    in_cmd,
  wapc_res_if.source  out_res
);

  localparam int STAGES     = 6;
  localparam int SEL_N      = 1 << SEL_W;
  localparam int ENC_PROD_W = ENC_W + ANGLE_W;
  localparam int RAMP_W     = ERR_W + SPEED_W;
  localparam int MUL_W      = PROD_W + RECIP_W;

  localparam logic [ENC_PROD_W-1:0] ENC_ROUND = ENC_PROD_W'(1) << (ENC_W - 1);
  localparam logic signed [ANGLE_W:0] DIFF_HALF = (ANGLE_W + 1)'(TURN_UNITS / 2);
  localparam logic signed [ANGLE_W:0] DIFF_TURN = (ANGLE_W + 1)'(TURN_UNITS);
  localparam logic signed [ANGLE_W-1:0] DELTA_HALF = ANGLE_W'(TURN_UNITS / 2);
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  typedef struct packed {
    logic [SEL_W-1:0]   sel;
    logic [ANGLE_W-1:0] tgt;
    logic [ENC_W-1:0]   enc;
  } s1_t;

  typedef struct packed {
    logic [SEL_W-1:0]   sel;
    logic [ANGLE_W-1:0] tgt;
    logic [ANGLE_W-1:0] cur_raw;
  } s2_t;

  typedef struct packed {
    logic [SEL_W-1:0]   sel;
    logic [ANGLE_W-1:0] safe;
    logic [ANGLE_W-1:0] cur;
    logic               tie_ok;
  } s3_t;

  typedef struct packed {
    logic [SEL_W-1:0]          sel;
    logic [ANGLE_W-1:0]        safe;
    logic signed [ANGLE_W-1:0] stgt;
    logic signed [ANGLE_W-1:0] delta;
    logic                      dir;
    logic [ERR_W-1:0]          err;
    logic                      full;
  } s4_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        safe;
    logic signed [ANGLE_W-1:0] stgt;
    logic signed [ANGLE_W-1:0] delta;
    logic                      dir;
    logic                      full;
    logic [PROD_W-1:0]         ramp;
  } s5_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        safe;
    logic signed [ANGLE_W-1:0] stgt;
    logic signed [ANGLE_W-1:0] delta;
    logic [SPEED_W-1:0]        speed;
    logic                      dir;
  } res_t;

  wapc_cfg_t         cfg;
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES-1:0] adv;
  logic [SEL_N-1:0]  held_r;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  s5_t  s5_r, s5_nxt;
  res_t out_r, out_nxt;

  wapc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  function automatic logic in_win(input logic [ANGLE_W-1:0] a,
                                  input logic [ANGLE_W-1:0] lo,
                                  input logic [ANGLE_W-1:0] hi);
    return (a >= lo) || (a <= hi);
  endfunction

  // outside the window hi < a < lo; nearer edge by 2a <= lo + hi, ties to hi
  function automatic logic [ANGLE_W-1:0] snap(input logic [ANGLE_W-1:0] a,
                                              input logic [ANGLE_W-1:0] lo,
                                              input logic [ANGLE_W-1:0] hi);
    logic [ANGLE_W:0] twice;
    logic [ANGLE_W:0] edges;
    twice = {a, 1'b0};
    edges = {1'b0, lo} + {1'b0, hi};
    if (in_win(a, lo, hi)) begin
      return a;
    end
    return (twice <= edges) ? hi : lo;
  endfunction

  // stage handshake: a stage moves when it is empty or its successor moves
  always_comb begin
    adv[STAGES-1] = !vld_r[STAGES-1] || out_res.ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt[0] = adv[0] ? in_cmd.valid : vld_r[0];
    for (int i = 1; i < STAGES; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  assign in_cmd.ready = adv[0];

  // stage 0: capture
  always_comb begin
    s1_nxt.sel = in_cmd.motor_select;
    s1_nxt.tgt = in_cmd.req_angle;
    s1_nxt.enc = in_cmd.encoder_position;
  end

  // stage 1: encoder counts to 0.01 degree, rounded; target wrapped to one turn
  logic [ENC_PROD_W-1:0] enc_prod;
  always_comb begin
    enc_prod       = ENC_PROD_W'(s1_r.enc) * ENC_PROD_W'(TURN_UNITS) + ENC_ROUND;
    s2_nxt.sel     = s1_r.sel;
    s2_nxt.tgt     = wrap_turn(s1_r.tgt);
    s2_nxt.cur_raw = enc_prod[ENC_W +: ANGLE_W];
  end

  // stage 2: window clamp
  logic [ANGLE_W-1:0] cur2;
  logic [ANGLE_W-1:0] lo2;
  logic [ANGLE_W-1:0] hi2;
  logic               has_win2;
  logic               cur_in2;
  always_comb begin
    cur2     = wrap_turn(s2_r.cur_raw);
    lo2      = cfg.lim_lo[s2_r.sel];
    hi2      = cfg.lim_hi[s2_r.sel];
    has_win2 = (32'(s2_r.sel) < 32'(MOTOR_COUNT));
    cur_in2  = in_win(cur2, lo2, hi2);
    s3_nxt.sel    = s2_r.sel;
    s3_nxt.cur    = cur2;
    // a clamped result always lies inside, so the tie rule only needs cur inside
    s3_nxt.tie_ok = has_win2 && cur_in2;
    if (!has_win2) begin
      s3_nxt.safe = s2_r.tgt;
    end else if (cur_in2) begin
      s3_nxt.safe = snap(s2_r.tgt, lo2, hi2);
    end else begin
      s3_nxt.safe = snap(cur2, lo2, hi2);
    end
  end

  // stage 3: wrapped delta, half-turn tie, direction hold
  logic signed [ANGLE_W:0] diff3;
  logic signed [ANGLE_W:0] dt3;
  logic signed [ANGLE_W:0] abs3;
  logic [ANGLE_W-1:0]      lo3;
  logic [ANGLE_W-1:0]      hi3;
  always_comb begin
    lo3   = cfg.lim_lo[s3_r.sel];
    hi3   = cfg.lim_hi[s3_r.sel];
    diff3 = $signed({1'b0, s3_r.safe}) - $signed({1'b0, s3_r.cur});
    if (diff3 > DIFF_HALF) begin
      dt3 = diff3 - DIFF_TURN;
    end else if (diff3 < -DIFF_HALF) begin
      dt3 = diff3 + DIFF_TURN;
    end else begin
      dt3 = diff3;
    end
    // half turn exactly: go the way that stays inside the window
    if (s3_r.tie_ok) begin
      if ((dt3 == -DIFF_HALF) && (s3_r.cur >= lo3) && (s3_r.safe <= hi3)) begin
        dt3 = DIFF_HALF;
      end else if ((dt3 == DIFF_HALF) && (s3_r.cur <= hi3) && (s3_r.safe >= lo3)) begin
        dt3 = -DIFF_HALF;
      end
    end
    abs3 = dt3[ANGLE_W] ? -dt3 : dt3;

    s4_nxt.sel   = s3_r.sel;
    s4_nxt.safe  = s3_r.safe;
    s4_nxt.stgt  = $signed((s3_r.safe > HALF_A) ? (s3_r.safe - TURN_A) : s3_r.safe);
    s4_nxt.delta = $signed(dt3[ANGLE_W-1:0]);
    s4_nxt.err   = abs3[ERR_W-1:0];
    s4_nxt.full  = (abs3[ERR_W-1:0] >= ERR_W'(FULL_ERROR));
    if (dt3 > 0) begin
      s4_nxt.dir = DIR_CW;
    end else if (dt3 < 0) begin
      s4_nxt.dir = DIR_CCW;
    end else begin
      s4_nxt.dir = held_r[s3_r.sel];
    end
  end

  // stage 4: ramp product err * span
  logic [SPEED_W-1:0] span4;
  logic [RAMP_W-1:0]  ramp4;
  always_comb begin
    span4 = (cfg.spd_ceil > cfg.spd_floor) ? (cfg.spd_ceil - cfg.spd_floor) : '0;
    ramp4 = RAMP_W'(s4_r.err) * RAMP_W'(span4);
    s5_nxt.safe  = s4_r.safe;
    s5_nxt.stgt  = s4_r.stgt;
    s5_nxt.delta = s4_r.delta;
    s5_nxt.dir   = s4_r.dir;
    s5_nxt.full  = s4_r.full;
    // only meaningful below full error, where it fits PROD_W
    s5_nxt.ramp  = ramp4[PROD_W-1:0];
  end

  // stage 5: divide by full error through the reciprocal, then the speed select
  logic [MUL_W-1:0]   quot5;
  logic [SPEED_W-1:0] step5;
  always_comb begin
    quot5 = MUL_W'(s5_r.ramp) * MUL_W'(RECIP);
    step5 = quot5[DIV_SHIFT +: SPEED_W];
    out_nxt.safe  = s5_r.safe;
    out_nxt.stgt  = s5_r.stgt;
    out_nxt.delta = s5_r.delta;
    out_nxt.dir   = s5_r.dir;
    out_nxt.speed = s5_r.full ? cfg.spd_ceil : (cfg.spd_floor + step5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      held_r <= {SEL_N{DIR_CW}};
    end else begin
      vld_r <= vld_nxt;
      if (vld_r[2] && adv[3]) begin
        held_r[s3_r.sel] <= s4_nxt.dir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_r <= s1_nxt;
    end
    if (adv[1]) begin
      s2_r <= s2_nxt;
    end
    if (adv[2]) begin
      s3_r <= s3_nxt;
    end
    if (adv[3]) begin
      s4_r <= s4_nxt;
    end
    if (adv[4]) begin
      s5_r <= s5_nxt;
    end
    if (adv[5]) begin
      out_r <= out_nxt;
    end
  end

  assign out_res.valid          = vld_r[STAGES-1];
  assign out_res.safe_target    = out_r.safe;
  assign out_res.centred_target = out_r.stgt;
  assign out_res.shortest_delta = out_r.delta;
  assign out_res.speed_cap      = out_r.speed;
  assign out_res.turn_direction = out_r.dir;

  // assertion helpers
  logic res_vld;
  logic res_dir_ok;
  logic res_in_half;
  logic s3_moves;
  assign res_vld     = vld_r[STAGES-1];
  assign res_dir_ok  = (out_r.delta == '0) || (out_r.dir == out_r.delta[ANGLE_W-1]);
  assign res_in_half = (out_r.delta >= -DELTA_HALF) && (out_r.delta <= DELTA_HALF);
  assign s3_moves    = vld_r[2] && adv[3];

  `WAPC_ASSERT_IMP(a_dir_follows_delta, res_vld, res_dir_ok, "turn direction disagrees")
  `WAPC_ASSERT_IMP(a_delta_in_half_turn, res_vld, res_in_half, "delta beyond half a turn")
  `WAPC_ASSERT_NXT(a_held_dir_updated, s3_moves, held_r[s4_r.sel] == s4_r.dir, "hold stale")

endmodule
